// File: rtl/core/asgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asgp_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int BUFFER_COUNT_DEF = 2;
  localparam logic [7:0] GAIN_RESET = 8'd32;

  typedef enum logic [2:0] {
    KIND_SAMPLE = 3'd0,
    KIND_CLAIM  = 3'd1,
    KIND_READ   = 3'd2,
    KIND_START  = 3'd3,
    KIND_STOP   = 3'd4
  } asgp_kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] adc_value;
    logic [7:0]  read_index;
  } asgp_in_t;

  typedef struct packed {
    logic       ready_res;
    logic       buffer_sel;
    logic [7:0] data;
    logic       stored;
  } asgp_out_t;

  // result fields known at accept time, plus a flag that data comes from the store
  typedef struct packed {
    asgp_out_t res;
    logic      from_ram;
  } asgp_stage_t;

  typedef struct packed {
    logic s1_valid;
    logic out_valid;
  } asgp_pipe_st_t;

  // center, scale by Q4.4 gain / 256 toward zero, offset, clamp to a byte
  function automatic logic [7:0] conv_sample(logic [11:0] adc, logic [7:0] gain);
    logic signed [11:0] centered;
    logic signed [20:0] prod;
    logic signed [20:0] biased;
    logic signed [12:0] scaled;
    logic signed [13:0] v;
    logic [7:0]         res;
    centered = signed'({~adc[11], adc[10:0]});
    prod     = centered * signed'({1'b0, gain});
    biased   = prod + (prod[20] ? 21'sd255 : 21'sd0);
    scaled   = signed'(biased[20:8]);
    v        = signed'({scaled[12], scaled} + 14'd128);
    if (v[13]) begin
      res = 8'd0;
    end else if (v > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/asgp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module asgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/asgp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module asgp_ctrl
  import asgp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
  localparam int DEPTH  = BUFFER_BYTES * BUFFER_COUNT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              accept,
  input  wire asgp_in_t          in_data,
  output asgp_stage_t            stage,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr
);

  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam int BUF_W = $clog2(BUFFER_COUNT);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(BUFFER_BYTES - 1);
  localparam logic [BUF_W-1:0]  BUF_LAST = BUF_W'(BUFFER_COUNT - 1);
  localparam logic [ADDR_W-1:0] BYTES_A  = ADDR_W'(BUFFER_BYTES);

  logic [7:0]       gain_r, gain_nxt;
  logic [BUF_W-1:0] wbuf_r, wbuf_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ready_r, ready_nxt;
  logic             run_r, run_nxt;

  logic [BUF_W-1:0] rbuf;
  logic [7:0]       conv;
  logic             idx_ok;

  assign rbuf   = (wbuf_r == BUF_LAST) ? '0 : wbuf_r + 1'b1;
  assign conv   = conv_sample(in_data.adc_value, gain_r);
  assign idx_ok = {24'd0, in_data.read_index} < 32'(BUFFER_BYTES);

  // store writes go to the write buffer, reads to a different one; an item reads only
  // after the previous item's write has landed, so no bypass is needed
  assign ram_waddr = ADDR_W'(wbuf_r) * BYTES_A + ADDR_W'(pos_r);
  assign ram_raddr = ADDR_W'(rbuf) * BYTES_A + ADDR_W'(in_data.read_index);
  assign ram_wdata = conv;

  always_comb begin
    gain_nxt  = cfg_valid ? cfg_data : gain_r;
    wbuf_nxt  = wbuf_r;
    pos_nxt   = pos_r;
    ready_nxt = ready_r;
    run_nxt   = run_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    stage.res.ready_res  = ready_r;
    stage.res.buffer_sel = rbuf[0];
    stage.res.data       = 8'd0;
    stage.res.stored     = 1'b0;
    stage.from_ram       = 1'b0;

    case (in_data.kind)
      KIND_SAMPLE: begin
        stage.res.data   = conv;
        stage.res.stored = run_r;
        if (accept && run_r) begin
          ram_we = 1'b1;
          if (pos_r == POS_LAST) begin
            ready_nxt = 1'b1;
            wbuf_nxt  = (wbuf_r == BUF_LAST) ? '0 : wbuf_r + 1'b1;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      KIND_CLAIM: begin
        if (accept) begin
          ready_nxt = 1'b0;
        end
      end
      KIND_READ: begin
        stage.from_ram = idx_ok;
        ram_re         = accept && idx_ok;
      end
      KIND_START, KIND_STOP: begin
        if (accept) begin
          wbuf_nxt  = '0;
          pos_nxt   = '0;
          ready_nxt = 1'b0;
          run_nxt   = (in_data.kind == KIND_START);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      wbuf_r  <= '0;
      pos_r   <= '0;
      ready_r <= 1'b0;
      run_r   <= 1'b0;
    end else begin
      gain_r  <= gain_nxt;
      wbuf_r  <= wbuf_nxt;
      pos_r   <= pos_nxt;
      ready_r <= ready_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/asgp_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module asgp_outq
  import asgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire asgp_stage_t stage,
  input  wire logic [7:0]  ram_rdata,
  input  wire logic        out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output asgp_out_t        out_data,
  output asgp_pipe_st_t    pipe_st
);

  logic        s1_valid_r, s1_valid_nxt;
  asgp_stage_t s1_r;
  logic        o_valid_r, o_valid_nxt;
  asgp_out_t   o_data_r;
  asgp_out_t   s1_res;
  logic        s1_move;

  // stage 1 waits for the store read; RAM read data holds until the next read
  assign s1_move  = !o_valid_r || !out_stall;
  assign in_stall = !rst_n || (s1_valid_r && !s1_move);

  always_comb begin
    s1_res = s1_r.res;
    if (s1_r.from_ram) begin
      s1_res.data = ram_rdata;
    end
  end

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    if (s1_valid_r && s1_move) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end else begin
      o_valid_nxt = o_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= stage;
    end
    if (s1_valid_r && s1_move) begin
      o_data_r <= s1_res;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_data         = o_data_r;
  assign pipe_st.s1_valid = s1_valid_r;
  assign pipe_st.out_valid = o_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/adc_sample_gain_pingpong_buffer_core.sv
// ADC sample gain ping-pong buffer.
// Input channel (in_valid / in_stall / in_data) carries one command per transaction:
// sample, claim, read byte, start or stop. Every command yields exactly one result
// transaction on the output channel (out_valid / out_stall / out_data).
// Samples are centered, scaled by the Q4.4 gain, offset and clamped to a byte; while
// running they are written into the current buffer, which flips when full.
// Gain is written through cfg_valid / cfg_data; cfg_ready is always high.
// A result passes through the read stage register and then the output register before out_valid.
// Throughput: one transaction per cycle while out_stall is low, set by the sample store doing
// one write or one registered read per item and the output register behind it.
// Reset clears the pointers, the ready flag and the running flag and sets gain to 2.0;
// the store itself is not cleared and reads of unwritten bytes are undefined.
// in_stall is high during reset.
// When the receiver stalls, the output register holds its result, one more item may be
// taken into the read stage, and then in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module adc_sample_gain_pingpong_buffer_core
  import asgp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire asgp_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output asgp_out_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int DEPTH  = BUFFER_BYTES * BUFFER_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              in_acc;
  asgp_stage_t       stage;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  asgp_pipe_st_t     pipe_st;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  asgp_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .BUFFER_COUNT(BUFFER_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .accept   (in_acc),
    .in_data  (in_data),
    .stage    (stage),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr)
  );

  asgp_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  asgp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .stage    (stage),
    .ram_rdata(ram_rdata),
    .out_stall(out_stall),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .pipe_st  (pipe_st)
  );

  // a store access only happens for an accepted item, and never both kinds at once
  a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || ram_re) |-> (in_acc && !(ram_we && ram_re)))
    else $error("store access without a single accepted item");

  a_acc_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pipe_st.s1_valid)
    else $error("accepted item did not reach the read stage");

  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_st.s1_valid && !pipe_st.out_valid) |=> pipe_st.out_valid)
    else $error("read stage did not move into an empty output register");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> pipe_st.s1_valid)
    else $error("store read issued without a waiting item");

endmodule
`default_nettype wire
